// ===== hdl/bmpu_pkg.sv =====
// Package of shared types and constants for the BMP pixel-data unpacker.
`default_nettype none

package bmpu_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned IDX_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  // The row counter wraps at 16 bits, whatever the image height.
  localparam int unsigned ROW_W      = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_PIXEL_MODE   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2,
    PH_SKIP  = 2'd3
  } phase_e;

  typedef enum logic {
    MODE_24BPP = 1'b0,
    MODE_32BPP = 1'b1
  } pixel_mode_e;

  typedef struct packed {
    logic [IDX_W-1:0]  pixel_index;
    logic [DATA_W-1:0] blue;
    logic [DATA_W-1:0] green;
    logic [DATA_W-1:0] red;
    logic              last_pixel;
  } pixel_t;

endpackage

`default_nettype wire

// ===== hdl/bmpu_byte_if.sv =====
// Input channel interface: one pixel-data byte per item.
`default_nettype none

interface bmpu_byte_if;
  logic                       valid;
  logic                       ready;
  logic [bmpu_pkg::DATA_W-1:0] data_byte;
  logic                       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/bmpu_pixel_if.sv =====
// Output channel interface: one unpacked pixel per item.
`default_nettype none

interface bmpu_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [bmpu_pkg::IDX_W-1:0]  pixel_index;
  logic [bmpu_pkg::DATA_W-1:0] blue;
  logic [bmpu_pkg::DATA_W-1:0] green;
  logic [bmpu_pkg::DATA_W-1:0] red;
  logic                        last_pixel;

  modport source (output valid, output pixel_index, output blue, output green,
                  output red, output last_pixel, input ready);
  modport sink (input valid, input pixel_index, input blue, input green,
                input red, input last_pixel, output ready);
endinterface

`default_nettype wire

// ===== hdl/bmpu_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
`default_nettype none

interface bmpu_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bmpu_pkg::CFG_IDX_W-1:0]  index;
  logic [bmpu_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== hdl/bmp_row_to_bgr_pixel_unpacker_core.sv =====
// Top level of the BMP pixel-data unpacker: byte counters and the pixel output register.
//
// Usage: pixel-data bytes of a bottom-up BMP enter on byte_in, one byte per item,
// in file order; first_byte marks the first byte of an image and clears all
// counters. The user writes width, height and pixel mode (24 or 32 bits per pixel) on
// cfg_in while the block is idle; the block does not enforce this. cfg is always ready.
// Each stored row's padding to a multiple of 4 bytes is dropped, as is the fourth
// byte of a 32-bit pixel. The item carrying a pixel's red byte produces one item on
// pix_out with blue, green, red and the top-down frame index (height-1-row)*width+col;
// last_pixel flags the final pixel, after which bytes are ignored until first_byte.
// A result is registered as its red byte is accepted and is on pix_out in the next cycle.
// Throughput: one byte per cycle when not stalled; the counters and the single output
// register update in the same cycle that a byte is accepted.
// Stall: byte_in stays ready while the output register is empty or being taken;
// if pix_out is held off with a pixel waiting, byte_in stalls until it is taken.
// Reset: asynchronous, active low; registers return to width 1, height 1, 24-bit
// mode and counters at row 0, column 0, with the output register empty.
`default_nettype none

module bmp_row_to_bgr_pixel_unpacker_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  bmpu_cfg_if.sink     cfg_in,
  bmpu_byte_if.sink    byte_in,
  bmpu_pixel_if.source pix_out
);
  import bmpu_pkg::*;

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMP_W = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;
  localparam int unsigned RCMP_W = (ROW_W > CFG_DATA_W) ? ROW_W : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] width, height;
  logic [IDX_W-1:0]      top_index;
  logic                  pixel_mode;

  bmpu_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg          (cfg_in),
    .width_o      (width),
    .height_o     (height),
    .top_index_o  (top_index),
    .pixel_mode_o (pixel_mode)
  );

  // Stream state.
  phase_e            phase_q, phase_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [1:0]        pad_q, pad_d;
  logic [1:0]        parity_q, parity_d;
  logic [IDX_W-1:0]  base_q, base_d;
  logic [DATA_W-1:0] held_blue_q, held_blue_d;
  logic [DATA_W-1:0] held_green_q, held_green_d;
  logic              done_q, done_d;

  // Output register.
  logic              out_valid_q;
  pixel_t            out_q, out_d;

  logic              in_accept;
  logic              emit;
  logic              end_pix;
  logic [CMP_W-1:0]  col_next;
  logic              is_last;

  assign byte_in.ready = !out_valid_q || pix_out.ready;
  assign in_accept     = byte_in.valid && byte_in.ready;

  always_comb begin
    phase_d      = phase_q;
    col_d        = col_q;
    row_d        = row_q;
    pad_d        = pad_q;
    parity_d     = parity_q;
    base_d       = base_q;
    held_blue_d  = held_blue_q;
    held_green_d = held_green_q;
    done_d       = done_q;
    emit         = 1'b0;
    end_pix      = 1'b0;
    is_last      = 1'b0;
    col_next     = '0;
    out_d        = out_q;

    // A first byte restarts the image before the byte itself is counted.
    if (byte_in.first_byte) begin
      phase_d      = PH_BLUE;
      col_d        = '0;
      row_d        = '0;
      pad_d        = '0;
      parity_d     = '0;
      base_d       = '0;
      held_blue_d  = '0;
      held_green_d = '0;
      done_d       = 1'b0;
    end

    if (done_d) begin
      // Everything after the final pixel is dropped.
    end else if (pad_d != 2'd0) begin
      pad_d = pad_d - 2'd1;
    end else begin
      parity_d = parity_d + 2'd1;
      is_last  = (RCMP_W'(row_d) >= RCMP_W'(height - CFG_DATA_W'(1))) &&
                 (CMP_W'(col_d) >= CMP_W'(width - CFG_DATA_W'(1)));
      case (phase_d)
        PH_BLUE: begin
          held_blue_d = byte_in.data_byte;
          phase_d     = PH_GREEN;
        end
        PH_GREEN: begin
          held_green_d = byte_in.data_byte;
          phase_d      = PH_RED;
        end
        PH_RED: begin
          emit              = 1'b1;
          out_d.pixel_index = IDX_W'(top_index - base_d + IDX_W'(col_d));
          out_d.blue        = held_blue_d;
          out_d.green       = held_green_d;
          out_d.red         = byte_in.data_byte;
          out_d.last_pixel  = is_last;
          if (is_last) begin
            done_d  = 1'b1;
            phase_d = PH_BLUE;
          end else if (pixel_mode == MODE_32BPP) begin
            phase_d = PH_SKIP;
          end else begin
            end_pix = 1'b1;
          end
        end
        default: begin
          end_pix = 1'b1;
        end
      endcase

      // Pixel end: a 24-bit pixel after its red byte, or any skipped fourth byte.
      if (end_pix) begin
        phase_d  = PH_BLUE;
        col_next = CMP_W'(col_d) + CMP_W'(1);
        if (col_next >= CMP_W'(width)) begin
          col_d    = '0;
          row_d    = row_d + ROW_W'(1);
          base_d   = base_d + IDX_W'(width);
          pad_d    = 2'd0 - parity_d;
          parity_d = '0;
        end else begin
          col_d = COL_W'(col_next);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_BLUE;
      col_q        <= '0;
      row_q        <= '0;
      pad_q        <= '0;
      parity_q     <= '0;
      base_q       <= '0;
      held_blue_q  <= '0;
      held_green_q <= '0;
      done_q       <= 1'b0;
    end else if (in_accept) begin
      phase_q      <= phase_d;
      col_q        <= col_d;
      row_q        <= row_d;
      pad_q        <= pad_d;
      parity_q     <= parity_d;
      base_q       <= base_d;
      held_blue_q  <= held_blue_d;
      held_green_q <= held_green_d;
      done_q       <= done_d;
    end
  end

  // The output register can refill in the same cycle that its pixel is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= emit;
    end else if (pix_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      out_q <= out_d;
    end
  end

  assign pix_out.valid       = out_valid_q;
  assign pix_out.pixel_index = out_q.pixel_index;
  assign pix_out.blue        = out_q.blue;
  assign pix_out.green       = out_q.green;
  assign pix_out.red         = out_q.red;
  assign pix_out.last_pixel  = out_q.last_pixel;

`ifndef SYNTH
  // Row padding is only armed at a pixel boundary.
  a_pad_at_boundary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_q != 2'd0) |-> (phase_q == PH_BLUE))
    else $error("pad bytes pending in the middle of a pixel");

  // Once the image is finished the byte phase sits at the start of a pixel.
  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (phase_q == PH_BLUE))
    else $error("image done with a pixel half assembled");

  // Sending the final pixel closes the image.
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && emit && out_d.last_pixel) |=> done_q)
    else $error("final pixel sent but image not marked done");

  // An empty output register never holds off the byte stream.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> byte_in.ready)
    else $error("byte input stalled with an empty output register");

  // A pixel waiting under stall keeps its contents.
  a_hold_under_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pix_out.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("pending pixel lost or changed under stall");
`endif

endmodule

`default_nettype wire

// ===== hdl/bmpu_cfg.sv =====
// Configuration registers with clamped dimensions and the registered top-row index.
`default_nettype none

module bmpu_cfg #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  bmpu_cfg_if.sink                             cfg,
  output logic [bmpu_pkg::CFG_DATA_W-1:0]      width_o,
  output logic [bmpu_pkg::CFG_DATA_W-1:0]      height_o,
  output logic [bmpu_pkg::IDX_W-1:0]           top_index_o,
  output logic                                 pixel_mode_o
);
  import bmpu_pkg::*;

  localparam int unsigned PROD_W = 2 * CFG_DATA_W;

  // Zero reads as one, and values above the maximum saturate. The result never
  // exceeds the larger of the raw value and one, so it fits the register field.
  function automatic logic [CFG_DATA_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] v,
                                                    input int unsigned maxv);
    logic [CFG_DATA_W-1:0] r;
    if (v == '0) begin
      r = CFG_DATA_W'(1);
    end else if (32'(v) > maxv) begin
      r = CFG_DATA_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [CFG_DATA_W-1:0] width_q, width_d;
  logic [CFG_DATA_W-1:0] height_q, height_d;
  logic [IDX_W-1:0]      top_q, top_d;
  logic                  mode_q, mode_d;
  logic [PROD_W-1:0]     prod;
  logic                  wr;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    if (wr) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  width_d  = eff_dim(cfg.wdata, MAX_WIDTH);
        REG_IMAGE_HEIGHT: height_d = eff_dim(cfg.wdata, MAX_HEIGHT);
        REG_PIXEL_MODE:   mode_d   = cfg.wdata[0];
        default: ;
      endcase
    end
    // One multiplier sees the new dimension and the one already held.
    prod  = PROD_W'(height_d - CFG_DATA_W'(1)) * PROD_W'(width_d);
    top_d = IDX_W'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DATA_W'(1);
      height_q <= CFG_DATA_W'(1);
      top_q    <= '0;
      mode_q   <= MODE_24BPP;
    end else if (wr) begin
      width_q  <= width_d;
      height_q <= height_d;
      top_q    <= top_d;
      mode_q   <= mode_d;
    end
  end

  assign width_o      = width_q;
  assign height_o     = height_q;
  assign top_index_o  = top_q;
  assign pixel_mode_o = mode_q;

endmodule

`default_nettype wire

// ===== verif/bmp_row_to_bgr_pixel_unpacker_core_test.sv =====
// Self-checking testbench for the BMP pixel-data unpacker core.
`timescale 1ns / 100ps

module bmp_row_to_bgr_pixel_unpacker_core_test;
  import bmpu_pkg::*;

  // Image size limits of the instance under test. Larger register values saturate.
  localparam int unsigned MAX_COLS = 4096;
  localparam int unsigned MAX_ROWS = 4096;
  // A pixel is registered as its red byte is accepted, so a few cycles of quiet are
  // plenty before the registers may be touched again.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Stop generating phases once this many byte items have been sent.
  localparam int unsigned TARGET_BYTES = 800;
  // Generous bound on the whole run, far above the slowest legal schedule.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Directed row pattern: corner byte values for a three-pixel row plus padding.
  localparam logic [7:0] ROW_PATTERN [12] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE,
                                              8'h55, 8'hAA, 8'h3C, 8'hC3, 8'h0F, 8'hF0};

  // Tracks the unpacker's counters byte by byte and holds the pixels it owes.
  class bmp_pixel_scoreboard;
    int unsigned max_cols;
    int unsigned max_rows;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    pixel_mode_e mode_reg;
    phase_e      phase;
    int unsigned col;
    logic [15:0] row;
    logic [1:0]  pad_left;
    logic [1:0]  row_parity;
    logic [23:0] row_base;
    logic [7:0]  held_blue;
    logic [7:0]  held_green;
    bit          image_done;
    pixel_t      pending_pixels[$];
    int unsigned pixel_mismatches;

    function new(int unsigned cols_limit, int unsigned rows_limit);
      max_cols = cols_limit;
      max_rows = rows_limit;
      width_reg = 13'd1;
      height_reg = 13'd1;
      mode_reg = MODE_24BPP;
      pixel_mismatches = 0;
      clear_counters();
    endfunction

    function void clear_counters();
      phase = PH_BLUE;
      col = 0;
      row = '0;
      pad_left = '0;
      row_parity = '0;
      row_base = '0;
      held_blue = '0;
      held_green = '0;
      image_done = 1'b0;
    endfunction

    function int unsigned clamp_dim(logic [12:0] v, int unsigned limit);
      if (v == 0) begin
        return 1;
      end
      if (v > limit) begin
        return limit;
      end
      return v;
    endfunction

    function int unsigned image_cols();
      return clamp_dim(width_reg, max_cols);
    endfunction

    function int unsigned image_rows();
      return clamp_dim(height_reg, max_rows);
    endfunction

    function void set_register(cfg_reg_e idx, logic [12:0] v);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = v;
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = v;
        end
        REG_PIXEL_MODE: begin
          mode_reg = pixel_mode_e'(v[0]);
        end
        default: begin
        end
      endcase
    endfunction

    // Steps past a finished pixel; the row end also schedules the pad bytes.
    function void close_pixel(int unsigned cols);
      phase = PH_BLUE;
      col++;
      if (col >= cols) begin
        col = 0;
        row = row + 16'd1;
        row_base = row_base + cols[23:0];
        pad_left = 2'd0 - row_parity;
        row_parity = '0;
      end
    endfunction

    // Consumes one accepted byte. Returns 0 when the block ignores it outright.
    function bit unpack_byte(logic [7:0] data, logic first);
      int unsigned cols;
      int unsigned rows;
      logic [23:0] top;
      pixel_t px;
      cols = image_cols();
      rows = image_rows();
      if (first) begin
        clear_counters();
      end
      if (image_done) begin
        return 1'b0;
      end
      if (pad_left != 0) begin
        pad_left = pad_left - 2'd1;
        return 1'b1;
      end
      row_parity = row_parity + 2'd1;
      case (phase)
        PH_BLUE: begin
          held_blue = data;
          phase = PH_GREEN;
        end
        PH_GREEN: begin
          held_green = data;
          phase = PH_RED;
        end
        PH_RED: begin
          top = 24'((rows - 1) * cols);
          px.pixel_index = top - row_base + col[23:0];
          px.blue = held_blue;
          px.green = held_green;
          px.red = data;
          px.last_pixel = (row >= rows - 1) && (col >= cols - 1);
          pending_pixels.push_back(px);
          if (px.last_pixel) begin
            image_done = 1'b1;
            phase = PH_BLUE;
          end else if (mode_reg == MODE_32BPP) begin
            phase = PH_SKIP;
          end else begin
            close_pixel(cols);
          end
        end
        default: begin
          close_pixel(cols);
        end
      endcase
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        pixel_mismatches++;
      end
    endfunction

    function void check_pixel(logic [23:0] idx, logic [7:0] b, logic [7:0] g,
                              logic [7:0] r, logic last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("pixel_index %0d arrived with no pixel outstanding", idx);
        pixel_mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("pixel_index", want.pixel_index, idx);
      compare_field("blue", 24'(want.blue), 24'(b));
      compare_field("green", 24'(want.green), 24'(g));
      compare_field("red", 24'(want.red), 24'(r));
      compare_field("last_pixel", 24'(want.last_pixel), 24'(last));
    endfunction

    function int unsigned pending_count();
      return pending_pixels.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  bmpu_cfg_if   cfg_if();
  bmpu_byte_if  byte_if();
  bmpu_pixel_if pix_if();

  bmp_row_to_bgr_pixel_unpacker_core #(
    .MAX_WIDTH (MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_in (cfg_if),
    .byte_in(byte_if),
    .pix_out(pix_if)
  );

  bmp_pixel_scoreboard sb;
  // While set, the pixel sink stays ready and the byte source only idles to wait for owed pixels.
  bit          steady = 1'b0;
  int unsigned counted_bytes = 0;
  int unsigned cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The run is bounded by a plain cycle counter; hitting it means something hung.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Pixel sink. Every accepted pixel is checked against the oldest outstanding
  // expectation, and ready is redrawn each cycle so the output register gets
  // held off at arbitrary points of the byte sequence.
  always @(posedge clk_i) begin
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      sb.check_pixel(pix_if.pixel_index, pix_if.blue, pix_if.green, pix_if.red,
                     pix_if.last_pixel);
    end
    pix_if.ready <= steady || ($urandom_range(0, 99) >= 38);
  end

  // Writes one configuration register. The caller lowers valid after the last write
  // so that back-to-back writes keep valid high without a glitch.
  task automatic cfg_write(cfg_reg_e idx, logic [12:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_register(idx, value);
  endtask

  // All three registers are written on every setting change.
  task automatic program_image(logic [12:0] cols, logic [12:0] rows, pixel_mode_e mode);
    cfg_write(REG_IMAGE_WIDTH, cols);
    cfg_write(REG_IMAGE_HEIGHT, rows);
    cfg_write(REG_PIXEL_MODE, {12'd0, mode});
    cfg_if.valid <= 1'b0;
  endtask

  // Presents one byte item and returns once it has been accepted. Random idle
  // cycles come first, and now and then the source holds off completely until
  // every pixel owed so far has been taken by the sink.
  task automatic drive_byte(logic [7:0] data, logic first);
    if ($urandom_range(0, 149) == 0) begin
      byte_if.valid <= 1'b0;
      do @(posedge clk_i); while (sb.pending_count() != 0);
    end
    if (!steady) begin
      while ($urandom_range(0, 99) < 38) begin
        byte_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= data;
    byte_if.first_byte <= first;
    do @(posedge clk_i); while (!byte_if.ready);
    void'(sb.unpack_byte(data, first));
    counted_bytes++;
  endtask

  // Sends a run of random bytes. The first item may open a new image, and any
  // later item may restart the image at random with the given odds.
  task automatic send_stream(int unsigned count, bit lead_first, int unsigned first_odds);
    for (int unsigned i = 0; i < count; i++) begin
      drive_byte(8'($urandom_range(0, 255)),
                 (i == 0 && lead_first) || ($urandom_range(0, first_odds - 1) == 0));
    end
  endtask

  // Waits until no pixel is owed, then lets the pipeline settle.
  task automatic drain_results();
    do @(posedge clk_i); while (sb.pending_count() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4096;
      3: return 13'd8191;
      4: return 13'($urandom_range(4097, 8190));
      default: return 13'($urandom_range(2, 4095));
    endcase
  endfunction

  initial begin
    int unsigned phase_no;
    int unsigned kind;
    int unsigned bpp;
    int unsigned row_bytes;
    int unsigned total;
    int unsigned cut;

    sb = new(MAX_COLS, MAX_ROWS);
    rst_ni <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= REG_IMAGE_WIDTH;
    cfg_if.wdata <= '0;
    byte_if.valid <= 1'b0;
    byte_if.data_byte <= '0;
    byte_if.first_byte <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Straight out of reset the image is one pixel, and counting starts without
    // any first_byte. The byte after that pixel must be ignored, and a first_byte
    // then rearms the same single-pixel image.
    drive_byte(8'h00, 1'b0);
    drive_byte(8'hFF, 1'b0);
    drive_byte(8'h7F, 1'b0);
    drive_byte(8'h55, 1'b0);
    drive_byte(8'hAA, 1'b1);
    drive_byte(8'h01, 1'b0);
    drive_byte(8'hFE, 1'b0);
    byte_if.valid <= 1'b0;

    // A 3x2 image in 24-bit mode: the bottom row has nine data bytes and three
    // pad bytes, which must be skipped.
    drain_results();
    program_image(13'd3, 13'd2, MODE_24BPP);
    for (int i = 0; i < 12; i++) begin
      drive_byte(ROW_PATTERN[i], i == 0);
    end
    byte_if.valid <= 1'b0;

    // Switch to 32-bit mode between rows without restarting the image; the
    // counters carry on, and the fourth byte of the pixel is dropped.
    drain_results();
    program_image(13'd3, 13'd2, MODE_32BPP);
    drive_byte(8'h12, 1'b0);
    drive_byte(8'h34, 1'b0);
    drive_byte(8'h56, 1'b0);
    drive_byte(8'h78, 1'b0);
    drive_byte(8'h9A, 1'b0);
    byte_if.valid <= 1'b0;

    // Random phases. Each one programs the registers while the block is idle and
    // then sends either a well-formed image (possibly cut short, with trailing
    // bytes or a stray restart), or a short burst that simply continues the
    // current counters, so that settings also change in the middle of a pixel
    // or an image. The first few phases pin the size registers at their extremes.
    phase_no = 0;
    while (counted_bytes < TARGET_BYTES) begin
      drain_results();
      steady = (phase_no >= 6 && phase_no < 12);
      case (phase_no)
        0: program_image(13'd8191, 13'd8191, MODE_32BPP);
        1: program_image(13'd0, 13'd0, MODE_24BPP);
        2: program_image(13'd4096, 13'd1, MODE_24BPP);
        3: program_image(13'd1, 13'd4096, MODE_32BPP);
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            program_image(pick_dim(), pick_dim(), pixel_mode_e'($urandom_range(0, 1)));
          end else begin
            program_image(13'($urandom_range(1, 7)), 13'($urandom_range(1, 5)),
                          pixel_mode_e'($urandom_range(0, 1)));
          end
        end
      endcase

      kind = $urandom_range(0, 9);
      if (kind == 7 || kind == 8) begin
        send_stream($urandom_range(1, 24), 1'b0, 16);
      end else begin
        bpp = (sb.mode_reg == MODE_32BPP) ? 4 : 3;
        row_bytes = sb.image_cols() * bpp;
        total = sb.image_rows() * (row_bytes + ((4 - row_bytes % 4) % 4));
        // Large images are only sampled at their start to keep the run short.
        if (total > 200) begin
          cut = $urandom_range(12, 60);
        end else if ($urandom_range(0, 4) == 0) begin
          cut = $urandom_range(1, total);
        end else begin
          cut = total + $urandom_range(0, 3);
        end
        send_stream(cut, kind != 9, 200);
      end
      byte_if.valid <= 1'b0;
      phase_no++;
    end

    drain_results();
    if (sb.pixel_mismatches == 0 && sb.pending_count() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bmpu_pkg.sv
hdl/bmpu_byte_if.sv
hdl/bmpu_pixel_if.sv
hdl/bmpu_cfg_if.sv
hdl/bmpu_cfg.sv
hdl/bmp_row_to_bgr_pixel_unpacker_core.sv
verif/bmp_row_to_bgr_pixel_unpacker_core_test.sv
